// ----- rtl/ifs_pkg.sv -----
package ifs_pkg;

    // endpoint width, fixed by the beat format
    localparam int EP_BITS = 16;
    // default store depth
    localparam int MAX_INTERVALS_DEF = 64;

    typedef struct packed {
        logic [EP_BITS-1:0] interval_start;
        logic [EP_BITS-1:0] interval_end;
        logic               last_interval;
    } t_in_beat;

    typedef struct packed {
        logic [EP_BITS-1:0] sorted_start;
        logic [EP_BITS-1:0] sorted_end;
        logic [EP_BITS-1:0] chosen_point;
        logic               order_ok;
        logic               overflow;
        logic               end_of_run;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_POPW,
        ST_PIVW,
        ST_SCAN,
        ST_CURW,
        ST_SWPW,
        ST_SWPWR,
        ST_PUSHA,
        ST_PUSHB,
        ST_OUTRD,
        ST_OUTW,
        ST_OUTH
    } t_state;

endpackage

// ----- rtl/interval_fuzzy_sort.sv -----
// Fuzzy interval sorter. Intervals are loaded one beat per cycle (endpoints put in
// order on the way in) into a MAX_INTERVALS-entry store; beats beyond capacity are
// dropped and flagged. The beat marked last starts a three-way quicksort that runs
// from an explicit range stack over one store with one read and one write port:
// each element visited in a partition is read and classed, and a swap writes
// both of its places; each range also pops, reads its pivot and pushes its
// sub-ranges. The sorted set then leaves one beat at a time, each held until
// accepted and carrying a witness point and a sticky ok flag. No input beat is
// taken from the last beat of a set until its final result beat is accepted.
module interval_fuzzy_sort #(
    parameter int MAX_INTERVALS = ifs_pkg::MAX_INTERVALS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ifs_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output ifs_pkg::t_out_beat o_data
);
    import ifs_pkg::*;

    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int DW = 2 * EP_BITS;
    localparam logic [CW-1:0] MAXC = CW'(MAX_INTERVALS);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] TWO = CW'(2);

    // storage
    logic [DW-1:0]   r_mem [MAX_INTERVALS];
    logic [DW-1:0]   r_rd;
    logic [2*CW-1:0] r_stk [MAX_INTERVALS];
    logic [2*CW-1:0] r_srd;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, r_sp, n_sp;
    logic [CW-1:0] r_l, n_l, r_r, n_r, r_i1, n_i1, r_j, n_j, r_k, n_k, r_part, n_part;
    logic          r_ovf, n_ovf, r_left, n_left, r_ok, n_ok, r_ovalid, n_ovalid;
    logic [EP_BITS-1:0] r_plo, n_plo, r_phi, n_phi, r_rp, n_rp;
    logic [DW-1:0] r_cur, n_cur, r_oth, n_oth;
    t_out_beat     r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [DW-1:0] mem_wd;
    logic          stk_we;
    logic [AW-1:0] stk_wa, stk_ra;
    logic [2*CW-1:0] stk_wd;

    logic [EP_BITS-1:0] in_lo, in_hi, rd_lo, rd_hi, pt;
    logic [CW-1:0] nn, jm;
    logic          room;

    assign rd_lo = r_rd[DW-1:EP_BITS];
    assign rd_hi = r_rd[EP_BITS-1:0];

    // interval store and range stack, one read and one write port each
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        r_srd <= r_stk[stk_ra];
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_sp     <= '0;
            r_ovf    <= 1'b0;
            r_ok     <= 1'b1;
            r_rp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sp     <= n_sp;
            r_ovf    <= n_ovf;
            r_ok     <= n_ok;
            r_rp     <= n_rp;
            r_ovalid <= n_ovalid;
        end
        r_l    <= n_l;
        r_r    <= n_r;
        r_i1   <= n_i1;
        r_j    <= n_j;
        r_k    <= n_k;
        r_part <= n_part;
        r_left <= n_left;
        r_plo  <= n_plo;
        r_phi  <= n_phi;
        r_cur  <= n_cur;
        r_oth  <= n_oth;
        r_out  <= n_out;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sp     = r_sp;
        n_ovf    = r_ovf;
        n_ok     = r_ok;
        n_rp     = r_rp;
        n_ovalid = r_ovalid;
        n_l      = r_l;
        n_r      = r_r;
        n_i1     = r_i1;
        n_j      = r_j;
        n_k      = r_k;
        n_part   = r_part;
        n_left   = r_left;
        n_plo    = r_plo;
        n_phi    = r_phi;
        n_cur    = r_cur;
        n_oth    = r_oth;
        n_out    = r_out;
        mem_we   = 1'b0;
        mem_wa   = r_cnt[AW-1:0];
        mem_wd   = '0;
        mem_ra   = r_k[AW-1:0];
        stk_we   = 1'b0;
        stk_wa   = r_sp[AW-1:0];
        stk_wd   = '0;
        stk_ra   = r_sp[AW-1:0];
        room     = r_cnt < MAXC;
        nn       = room ? r_cnt + ONE : r_cnt;
        jm       = r_j - ONE;
        pt       = (rd_lo > r_rp) ? rd_lo : r_rp;
        if (i_data.interval_start > i_data.interval_end) begin
            in_lo = i_data.interval_end;
            in_hi = i_data.interval_start;
        end else begin
            in_lo = i_data.interval_start;
            in_hi = i_data.interval_end;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (room) begin
                        mem_we = 1'b1;
                        mem_wd = {in_lo, in_hi};
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_cnt = nn;
                    if (i_data.last_interval) begin
                        n_rp = '0;
                        n_ok = 1'b1;
                        n_k  = '0;
                        if (nn < TWO) begin
                            n_state = ST_OUTRD;
                        end else begin
                            stk_we  = 1'b1;
                            stk_wa  = '0;
                            stk_wd  = {CW'(0), nn - ONE};
                            n_sp    = ONE;
                            n_state = ST_POP;
                        end
                    end
                end
            end
            ST_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = ST_OUTRD;
                end else begin
                    n_sp    = r_sp - ONE;
                    stk_ra  = n_sp[AW-1:0];
                    n_state = ST_POPW;
                end
            end
            ST_POPW: begin
                n_l     = r_srd[2*CW-1:CW];
                n_r     = r_srd[CW-1:0];
                mem_ra  = n_r[AW-1:0];
                n_state = ST_PIVW;
            end
            ST_PIVW: begin
                n_plo   = rd_lo;
                n_phi   = rd_hi;
                n_i1    = r_l;
                n_j     = r_r + ONE;
                n_k     = r_l;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_k < r_j && r_k <= r_r) begin
                    mem_ra  = r_k[AW-1:0];
                    n_state = ST_CURW;
                end else begin
                    n_state = ST_PUSHA;
                end
            end
            ST_CURW: begin
                n_cur   = r_rd;
                n_state = ST_SCAN;
                if (rd_hi < r_plo) begin
                    // wholly below the pivot
                    if (r_i1 == r_k) begin
                        n_i1 = r_i1 + ONE;
                        n_k  = r_k + ONE;
                    end else begin
                        n_part  = r_i1;
                        n_left  = 1'b1;
                        mem_ra  = r_i1[AW-1:0];
                        n_state = ST_SWPW;
                    end
                end else if (rd_lo > r_phi) begin
                    // wholly above the pivot
                    n_j = jm;
                    if (jm != r_k) begin
                        n_part  = jm;
                        n_left  = 1'b0;
                        mem_ra  = jm[AW-1:0];
                        n_state = ST_SWPW;
                    end
                end else begin
                    // overlap: narrow the pivot
                    if (rd_lo > r_plo) begin
                        n_plo = rd_lo;
                    end
                    if (rd_hi < r_phi) begin
                        n_phi = rd_hi;
                    end
                    n_k = r_k + ONE;
                end
            end
            ST_SWPW: begin
                mem_we  = 1'b1;
                mem_wa  = r_part[AW-1:0];
                mem_wd  = r_cur;
                n_oth   = r_rd;
                n_state = ST_SWPWR;
            end
            ST_SWPWR: begin
                mem_we  = 1'b1;
                mem_wa  = r_k[AW-1:0];
                mem_wd  = r_oth;
                if (r_left) begin
                    n_i1 = r_i1 + ONE;
                    n_k  = r_k + ONE;
                end
                n_state = ST_SCAN;
            end
            ST_PUSHA: begin
                if (r_l + ONE < r_i1 && r_sp < MAXC) begin
                    stk_we = 1'b1;
                    stk_wd = {r_l, r_i1 - ONE};
                    n_sp   = r_sp + ONE;
                end
                n_state = ST_PUSHB;
            end
            ST_PUSHB: begin
                if (r_j < r_r && r_sp < MAXC) begin
                    stk_we = 1'b1;
                    stk_wd = {r_j, r_r};
                    n_sp   = r_sp + ONE;
                end
                n_state = ST_POP;
            end
            ST_OUTRD: begin
                mem_ra  = r_k[AW-1:0];
                n_state = ST_OUTW;
            end
            ST_OUTW: begin
                n_rp               = pt;
                n_ok               = r_ok && !(pt > rd_hi);
                n_out.sorted_start = rd_lo;
                n_out.sorted_end   = rd_hi;
                n_out.chosen_point = pt;
                n_out.order_ok     = n_ok;
                n_out.overflow     = r_ovf;
                n_out.end_of_run   = (r_k == r_cnt - ONE);
                n_ovalid           = 1'b1;
                n_state            = ST_OUTH;
            end
            ST_OUTH: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    if (r_out.end_of_run) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_rp    = '0;
                        n_ok    = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + ONE;
                        n_state = ST_OUTRD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

// ----- rtl/ifs_checker.sv -----
module ifs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input ifs_pkg::t_in_beat  i_data,
    input logic               o_valid,
    input logic               i_stall,
    input ifs_pkg::t_out_beat o_data
);
    // a stalled result beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat withdrawn under stall");

    // no input taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // ok flag cannot claim a point beyond the interval end
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.order_ok && (o_data.chosen_point > o_data.sorted_end)))
        else $error("order_ok set with point past end");

    // witness point never below the start, interval well formed
    a_pt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.chosen_point >= o_data.sorted_start)
                 && (o_data.sorted_start <= o_data.sorted_end))
        else $error("bad witness point or interval");
endmodule

bind interval_fuzzy_sort ifs_checker u_ifs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ----- dv/interval_fuzzy_sort_test.sv -----
module interval_fuzzy_sort_test;
    import ifs_pkg::*;

    localparam int CAP       = MAX_INTERVALS_DEF;
    localparam int CYC_LIMIT = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;

    interval_fuzzy_sort dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // predictor state
    logic [EP_BITS-1:0] lo_store [CAP];
    logic [EP_BITS-1:0] hi_store [CAP];
    int                 held;
    logic               dropped;
    t_out_beat          sorted_q [$];

    int  err_cnt;
    int  cyc;
    bit  hold_rx;
    int  hold_len;
    bit  rx_busy;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // swap two stored intervals
    task automatic swap_iv(int p, int q);
        logic [EP_BITS-1:0] t;
        t = lo_store[p]; lo_store[p] = lo_store[q]; lo_store[q] = t;
        t = hi_store[p]; hi_store[p] = hi_store[q]; hi_store[q] = t;
    endtask

    // three-way fuzzy partition of [l, r]
    task automatic fuzzy_split(int l, int r, output int lt, output int gt);
        logic [EP_BITS-1:0] plo, phi;
        int i, j, k;
        plo = lo_store[r];
        phi = hi_store[r];
        i = l - 1;
        j = r + 1;
        k = l;
        while (k < j && k <= r) begin
            if (hi_store[k] < plo) begin
                i++;
                swap_iv(i, k);
                k++;
            end else if (lo_store[k] > phi) begin
                j--;
                swap_iv(j, k);
            end else begin
                if (lo_store[k] > plo) plo = lo_store[k];
                if (hi_store[k] < phi) phi = hi_store[k];
                k++;
            end
        end
        lt = i;
        gt = j;
    endtask

    // sort the held set and queue its output beats
    task automatic sort_and_emit();
        int stk_l [CAP];
        int stk_r [CAP];
        int sp, l, r, lt, gt, k;
        logic [EP_BITS-1:0] pt;
        logic ok;
        t_out_beat b;
        if (held >= 2) begin
            stk_l[0] = 0;
            stk_r[0] = held - 1;
            sp = 1;
            while (sp > 0) begin
                sp--;
                l = stk_l[sp];
                r = stk_r[sp];
                fuzzy_split(l, r, lt, gt);
                if (l < lt && sp < CAP) begin
                    stk_l[sp] = l; stk_r[sp] = lt; sp++;
                end
                if (gt < r && sp < CAP) begin
                    stk_l[sp] = gt; stk_r[sp] = r; sp++;
                end
            end
        end
        pt = '0;
        ok = 1'b1;
        for (k = 0; k < held; k++) begin
            if (lo_store[k] > pt) pt = lo_store[k];
            if (pt > hi_store[k]) ok = 1'b0;
            b.sorted_start = lo_store[k];
            b.sorted_end   = hi_store[k];
            b.chosen_point = pt;
            b.order_ok     = ok;
            b.overflow     = dropped;
            b.end_of_run   = (k == held - 1);
            sorted_q.push_back(b);
        end
        held = 0;
        dropped = 1'b0;
    endtask

    // model one accepted input beat
    task automatic predict_beat(t_in_beat d);
        logic [EP_BITS-1:0] s, e;
        s = d.interval_start;
        e = d.interval_end;
        if (s > e) begin
            s = d.interval_end;
            e = d.interval_start;
        end
        if (held < CAP) begin
            lo_store[held] = s;
            hi_store[held] = e;
            held++;
        end else begin
            dropped = 1'b1;
        end
        if (d.last_interval) sort_and_emit();
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // send one beat, with an optional gap before it
    task automatic send_beat(logic [EP_BITS-1:0] s, logic [EP_BITS-1:0] e, logic last,
                             bit idle_ok);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data.interval_start <= s;
        i_data.interval_end   <= e;
        i_data.last_interval  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_beat(i_data);
    endtask

    task automatic idle_tx();
        i_valid <= 1'b0;
        i_data  <= '0;
    endtask

    // receiver stall pattern; a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (rx_busy) begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sorted_q.size() == 0) begin
                $error("result beat with nothing expected: %h", o_data);
                err_cnt++;
            end else begin
                x = sorted_q.pop_front();
                if (o_data.sorted_start !== x.sorted_start) begin
                    $error("sorted_start exp %h got %h", x.sorted_start, o_data.sorted_start);
                    err_cnt++;
                end
                if (o_data.sorted_end !== x.sorted_end) begin
                    $error("sorted_end exp %h got %h", x.sorted_end, o_data.sorted_end);
                    err_cnt++;
                end
                if (o_data.chosen_point !== x.chosen_point) begin
                    $error("chosen_point exp %h got %h", x.chosen_point, o_data.chosen_point);
                    err_cnt++;
                end
                if (o_data.order_ok !== x.order_ok) begin
                    $error("order_ok exp %b got %b", x.order_ok, o_data.order_ok);
                    err_cnt++;
                end
                if (o_data.overflow !== x.overflow) begin
                    $error("overflow exp %b got %b", x.overflow, o_data.overflow);
                    err_cnt++;
                end
                if (o_data.end_of_run !== x.end_of_run) begin
                    $error("end_of_run exp %b got %b", x.end_of_run, o_data.end_of_run);
                    err_cnt++;
                end
            end
        end
    end

    function automatic logic [EP_BITS-1:0] rand_ep(int mode);
        case (mode)
            0:       return EP_BITS'($urandom_range(0, 65535));
            1:       return EP_BITS'($urandom_range(1000, 1200));
            2:       return EP_BITS'($urandom_range(0, 7));
            default: return EP_BITS'($urandom_range(65528, 65535));
        endcase
    endfunction

    // extremes, swap on load, single interval, identical intervals
    task automatic test_directed();
        send_beat(16'h0000, 16'hffff, 1'b0, 1'b0);
        send_beat(16'hffff, 16'h0000, 1'b0, 1'b0);
        send_beat(16'h8000, 16'h8000, 1'b0, 1'b0);
        send_beat(16'h0010, 16'h0005, 1'b0, 1'b0);
        send_beat(16'hfff0, 16'hfffe, 1'b0, 1'b0);
        send_beat(16'h5555, 16'haaaa, 1'b1, 1'b0);
        send_beat(16'h1234, 16'h1234, 1'b1, 1'b1);
        send_beat(16'h0000, 16'h0000, 1'b0, 1'b1);
        send_beat(16'hffff, 16'hffff, 1'b1, 1'b1);
        send_beat(16'h0100, 16'h0200, 1'b0, 1'b1);
        send_beat(16'h0100, 16'h0200, 1'b0, 1'b1);
        send_beat(16'h0100, 16'h0200, 1'b1, 1'b1);
        // disjoint, reverse order: order_ok must hold
        send_beat(16'h0900, 16'h0a00, 1'b0, 1'b1);
        send_beat(16'h0500, 16'h0600, 1'b0, 1'b1);
        send_beat(16'h0100, 16'h0200, 1'b1, 1'b1);
        // nested overlap
        send_beat(16'h0000, 16'hffff, 1'b0, 1'b1);
        send_beat(16'h0010, 16'h0020, 1'b0, 1'b1);
        send_beat(16'h0030, 16'h0040, 1'b1, 1'b1);
    endtask

    // store full: an overflowing set whose last beat is dropped, and an exactly full set
    task automatic test_overflow();
        int k;
        for (k = 0; k < CAP + 3; k++)
            send_beat(rand_ep(0), rand_ep(0), 1'b0, 1'b0);
        send_beat(rand_ep(0), rand_ep(0), 1'b1, 1'b1);
        for (k = 0; k < CAP - 1; k++)
            send_beat(rand_ep(2), rand_ep(2), 1'b0, 1'b1);
        send_beat(rand_ep(3), rand_ep(3), 1'b1, 1'b1);
    endtask

    // random sets, mostly small
    task automatic test_random(int n_items);
        int sent, sz, k, mode;
        sent = 0;
        while (sent < n_items) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                             : $urandom_range(1, 8);
            mode = $urandom_range(0, 3);
            for (k = 0; k < sz; k++)
                send_beat(rand_ep(mode), rand_ep(mode), k == sz - 1, 1'b1);
            sent += sz;
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        int k;
        hold_rx = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            begin
                for (k = 0; k < 6; k++)
                    send_beat(rand_ep(0), rand_ep(0), k == 5, 1'b0);
                for (k = 0; k < 4; k++)
                    send_beat(rand_ep(1), rand_ep(1), k == 3, 1'b0);
            end
        join
    endtask

    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_stall = 1'b0;
        err_cnt = 0;
        cyc     = 0;
        hold_rx = 1'b0;
        rx_busy = 1'b1;
        held    = 0;
        dropped = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_random(150);
        idle_tx();

        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- interval_fuzzy_sort.f -----
rtl/ifs_pkg.sv
rtl/interval_fuzzy_sort.sv
rtl/ifs_checker.sv
dv/interval_fuzzy_sort_test.sv
